/* rtl/cca_pkg.sv */
// ============================================================================
// cca_pkg: shared types, constants and helpers for the calendar clock
// Beat layouts for the command and result channels, calendar constants and
// the constant-reciprocal dividers used by the delta split pipeline.
// ============================================================================
package cca_pkg;

	localparam int unsigned DELTA_MAX_W     = 20;
	localparam int unsigned DELTA_WIDTH_DEF = 20;

	// widths of the split delta: minutes, hours and whole days
	localparam int unsigned Q1_W   = 15;
	localparam int unsigned Q2_W   = 9;
	localparam int unsigned DAYS_W = 4;

	localparam logic MODE_ADVANCE = 1'b0;
	localparam logic MODE_LOAD    = 1'b1;

	localparam logic [3:0] MON_JAN = 4'd1;
	localparam logic [3:0] MON_FEB = 4'd2;
	localparam logic [3:0] MON_APR = 4'd4;
	localparam logic [3:0] MON_JUN = 4'd6;
	localparam logic [3:0] MON_SEP = 4'd9;
	localparam logic [3:0] MON_NOV = 4'd11;
	localparam logic [3:0] MON_DEC = 4'd12;

	localparam logic [13:0] YEAR_LOAD_MAX = 14'd10000;
	localparam logic [13:0] YEAR_TOP      = 14'd16383;
	localparam logic [8:0]  CYCLE_LAST    = 9'd399;

	localparam logic [5:0] SEC_MAX  = 6'd59;
	localparam logic [4:0] HOUR_MAX = 5'd23;

	// reciprocals: exact quotient over the full operand range
	localparam logic [20:0] RECIP60    = 21'd1118482;
	localparam int unsigned RECIP60_SH = 26;
	localparam logic [8:0]  RECIP24    = 9'd342;
	localparam int unsigned RECIP24_SH = 13;
	localparam logic [13:0] RECIP400   = 14'd10486;
	localparam int unsigned RECIP400_SH = 22;

	typedef struct packed {
		logic        mode;
		logic [19:0] delta_seconds;
		logic [13:0] load_year;
		logic [3:0]  load_month;
		logic [4:0]  load_day;
		logic [4:0]  load_hour;
		logic [5:0]  load_minute;
		logic [5:0]  load_second;
	} cmd_beat_t;

	typedef struct packed {
		logic [13:0] cur_year;
		logic [3:0]  cur_month;
		logic [4:0]  cur_day;
		logic [4:0]  cur_hour;
		logic [5:0]  cur_minute;
		logic [5:0]  cur_second;
		logic        year_wrapped;
	} res_beat_t;

	// item after the split: delta as day/hour/minute/second digits, load clamped
	typedef struct packed {
		logic              mode;
		logic [DAYS_W-1:0] add_days;
		logic [4:0]        add_hours;
		logic [5:0]        add_minutes;
		logic [5:0]        add_seconds;
		logic [13:0]       ld_year;
		logic [8:0]        ld_cycle;
		logic [3:0]        ld_month;
		logic [4:0]        ld_day;
		logic [4:0]        ld_hour;
		logic [5:0]        ld_minute;
		logic [5:0]        ld_second;
	} split_beat_t;

	function automatic logic [Q1_W-1:0] div60(input logic [DELTA_MAX_W-1:0] x);
		logic [40:0] p;
		p = 41'(x) * 41'(RECIP60);
		return p[RECIP60_SH +: Q1_W];
	endfunction

	function automatic logic [4:0] div24(input logic [Q2_W-1:0] x);
		logic [17:0] p;
		p = 18'(x) * 18'(RECIP24);
		return p[RECIP24_SH +: 5];
	endfunction

	function automatic logic [5:0] div400(input logic [13:0] y);
		logic [27:0] p;
		p = 28'(y) * 28'(RECIP400);
		return p[RECIP400_SH +: 6];
	endfunction

	// leap test from the year's position in the 400 year cycle
	function automatic logic leap_from_cycle(input logic [8:0] r);
		return (r[1:0] == 2'd0) && (r != 9'd100) && (r != 9'd200) && (r != 9'd300);
	endfunction

	function automatic logic [4:0] month_length(input logic [3:0] month, input logic leap);
		logic [4:0] len;
		if (month inside {MON_APR, MON_JUN, MON_SEP, MON_NOV}) begin
			len = 5'd30;
		end else if (month == MON_FEB) begin
			len = leap ? 5'd29 : 5'd28;
		end else begin
			len = 5'd31;
		end
		return len;
	endfunction

endpackage

/* rtl/cca_split.sv */
// ============================================================================
// cca_split: input register and delta split pipeline
// Takes the command beat, splits the delta into second, minute, hour and day
// digits over three stages and clamps the load fields on the way.
// ============================================================================
module cca_split import cca_pkg::*; #(
	parameter int unsigned DELTA_WIDTH = DELTA_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	output logic        cmd_stall,
	input  cmd_beat_t   cmd,
	output logic        split_valid,
	input  logic        split_take,
	output split_beat_t split_beat
);

	// stage 1: raw beat
	logic                   v_s1;
	logic                   mode_s1;
	logic [DELTA_WIDTH-1:0] delta_s1;
	logic [13:0]            year_s1;
	logic [3:0]             month_s1;
	logic [4:0]             day_s1;
	logic [4:0]             hour_s1;
	logic [5:0]             minute_s1;
	logic [5:0]             second_s1;

	// stage 2: seconds digit, load fields clamped except day upper bound
	logic            v_s2;
	logic            mode_s2;
	logic [Q1_W-1:0] q1_s2;
	logic [5:0]      rsec_s2;
	logic [13:0]     year_s2;
	logic [3:0]      month_s2;
	logic [4:0]      day_s2;
	logic [4:0]      hour_s2;
	logic [5:0]      minute_s2;
	logic [5:0]      second_s2;

	// stage 3: minutes digit, position of load year in the 400 year cycle
	logic            v_s3;
	logic            mode_s3;
	logic [Q2_W-1:0] q2_s3;
	logic [5:0]      rmin_s3;
	logic [5:0]      rsec_s3;
	logic [13:0]     year_s3;
	logic [8:0]      cycle_s3;
	logic [3:0]      month_s3;
	logic [4:0]      day_s3;
	logic [4:0]      hour_s3;
	logic [5:0]      minute_s3;
	logic [5:0]      second_s3;

	logic        v_s4;
	split_beat_t beat_s4;

	logic en_s1, en_s2, en_s3, en_s4;

	assign en_s4 = !v_s4 || split_take;
	assign en_s3 = !v_s3 || en_s4;
	assign en_s2 = !v_s2 || en_s3;
	assign en_s1 = !v_s1 || en_s2;

	assign cmd_stall   = !en_s1;
	assign split_valid = v_s4;
	assign split_beat  = beat_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= cmd_valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			mode_s1   <= cmd.mode;
			delta_s1  <= cmd.delta_seconds[DELTA_WIDTH-1:0];
			year_s1   <= cmd.load_year;
			month_s1  <= cmd.load_month;
			day_s1    <= cmd.load_day;
			hour_s1   <= cmd.load_hour;
			minute_s1 <= cmd.load_minute;
			second_s1 <= cmd.load_second;
		end
	end

	// stage 2 logic
	logic [DELTA_MAX_W-1:0] delta_ext;
	logic [Q1_W-1:0]        q1_c;
	logic [DELTA_MAX_W-1:0] q1x60;

	assign delta_ext = DELTA_MAX_W'(delta_s1);
	assign q1_c      = div60(delta_ext);
	assign q1x60     = DELTA_MAX_W'(q1_c) * DELTA_MAX_W'(60);

	always_ff @(posedge clk) begin
		if (en_s2) begin
			mode_s2   <= mode_s1;
			q1_s2     <= q1_c;
			rsec_s2   <= 6'(delta_ext - q1x60);
			year_s2   <= (year_s1 > YEAR_LOAD_MAX) ? YEAR_LOAD_MAX : year_s1;
			month_s2  <= (month_s1 < MON_JAN) ? MON_JAN :
			             (month_s1 > MON_DEC) ? MON_DEC : month_s1;
			day_s2    <= (day_s1 == 5'd0) ? 5'd1 : day_s1;
			hour_s2   <= (hour_s1 > HOUR_MAX) ? HOUR_MAX : hour_s1;
			minute_s2 <= (minute_s1 > SEC_MAX) ? SEC_MAX : minute_s1;
			second_s2 <= (second_s1 > SEC_MAX) ? SEC_MAX : second_s1;
		end
	end

	// stage 3 logic
	logic [Q1_W-1:0] q2_full;
	logic [Q2_W-1:0] q2_c;
	logic [Q1_W-1:0] q2x60;
	logic [5:0]      yq_c;
	logic [13:0]     yx400;

	assign q2_full = div60(DELTA_MAX_W'(q1_s2));
	assign q2_c    = q2_full[Q2_W-1:0];
	assign q2x60   = Q1_W'(q2_c) * Q1_W'(60);
	assign yq_c    = div400(year_s2);
	assign yx400   = 14'(yq_c) * 14'(400);

	always_ff @(posedge clk) begin
		if (en_s3) begin
			mode_s3   <= mode_s2;
			q2_s3     <= q2_c;
			rmin_s3   <= 6'(q1_s2 - q2x60);
			rsec_s3   <= rsec_s2;
			year_s3   <= year_s2;
			cycle_s3  <= 9'(year_s2 - yx400);
			month_s3  <= month_s2;
			day_s3    <= day_s2;
			hour_s3   <= hour_s2;
			minute_s3 <= minute_s2;
			second_s3 <= second_s2;
		end
	end

	// stage 4 logic
	logic [4:0]        dq_c;
	logic [DAYS_W-1:0] days_c;
	logic [Q2_W-1:0]   dx24;
	logic [4:0]        ld_len;

	assign dq_c   = div24(q2_s3);
	assign days_c = dq_c[DAYS_W-1:0];
	assign dx24   = Q2_W'(days_c) * Q2_W'(24);
	assign ld_len = month_length(month_s3, leap_from_cycle(cycle_s3));

	always_ff @(posedge clk) begin
		if (en_s4) begin
			beat_s4.mode        <= mode_s3;
			beat_s4.add_days    <= days_c;
			beat_s4.add_hours   <= 5'(q2_s3 - dx24);
			beat_s4.add_minutes <= rmin_s3;
			beat_s4.add_seconds <= rsec_s3;
			beat_s4.ld_year     <= year_s3;
			beat_s4.ld_cycle    <= cycle_s3;
			beat_s4.ld_month    <= month_s3;
			beat_s4.ld_day      <= (day_s3 > ld_len) ? ld_len : day_s3;
			beat_s4.ld_hour     <= hour_s3;
			beat_s4.ld_minute   <= minute_s3;
			beat_s4.ld_second   <= second_s3;
		end
	end

endmodule

/* rtl/cca_core.sv */
// ============================================================================
// cca_core: calendar state and result register
// Adds the split delta digits to the counters with one carry per field and at
// most one month carry, or loads the clamped fields, and registers the result.
// ============================================================================
module cca_core import cca_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        split_valid,
	output logic        split_take,
	input  split_beat_t split_beat,
	output logic        res_valid,
	input  logic        res_stall,
	output res_beat_t   res
);

	logic [5:0]  sec_q;
	logic [5:0]  min_q;
	logic [4:0]  hour_q;
	logic [4:0]  day_q;
	logic [3:0]  month_q;
	logic [13:0] year_q;
	logic [8:0]  cycle_q;
	logic        res_valid_q;
	res_beat_t   res_q;

	logic step;

	assign split_take = !res_valid_q || !res_stall;
	assign step       = split_valid && split_take;
	assign res_valid  = res_valid_q;
	assign res        = res_q;

	logic       leap_cur;
	logic [6:0] s_sum, m_sum;
	logic [5:0] h_sum, d_sum;
	logic       c_sec, c_min, c_hour, c_month;
	logic [4:0] len_cur;

	assign leap_cur = leap_from_cycle(cycle_q);
	assign len_cur  = month_length(month_q, leap_cur);

	assign s_sum  = 7'(sec_q) + 7'(split_beat.add_seconds);
	assign c_sec  = s_sum >= 7'd60;
	assign m_sum  = 7'(min_q) + 7'(split_beat.add_minutes) + 7'(c_sec);
	assign c_min  = m_sum >= 7'd60;
	assign h_sum  = 6'(hour_q) + 6'(split_beat.add_hours) + 6'(c_min);
	assign c_hour = h_sum >= 6'd24;
	assign d_sum  = 6'(day_q) + 6'(split_beat.add_days) + 6'(c_hour);
	assign c_month = d_sum > 6'(len_cur);

	logic [5:0]  sec_n, min_n;
	logic [4:0]  hour_n, day_n;
	logic [3:0]  month_n;
	logic [13:0] year_n;
	logic [8:0]  cycle_n;
	logic        wrap_n;

	always_comb begin
		sec_n   = c_sec  ? 6'(s_sum - 7'd60) : s_sum[5:0];
		min_n   = c_min  ? 6'(m_sum - 7'd60) : m_sum[5:0];
		hour_n  = c_hour ? 5'(h_sum - 6'd24) : h_sum[4:0];
		day_n   = c_month ? 5'(d_sum - 6'(len_cur)) : d_sum[4:0];
		month_n = month_q;
		year_n  = year_q;
		cycle_n = cycle_q;
		wrap_n  = 1'b0;
		if (c_month) begin
			if (month_q == MON_DEC) begin
				month_n = MON_JAN;
				if (year_q == YEAR_TOP) begin
					// wrap to year zero, which starts a fresh 400 year cycle
					year_n  = 14'd0;
					cycle_n = 9'd0;
					wrap_n  = 1'b1;
				end else begin
					year_n  = year_q + 14'd1;
					cycle_n = (cycle_q == CYCLE_LAST) ? 9'd0 : cycle_q + 9'd1;
				end
			end else begin
				month_n = month_q + 4'd1;
			end
		end
		if (split_beat.mode == MODE_LOAD) begin
			sec_n   = split_beat.ld_second;
			min_n   = split_beat.ld_minute;
			hour_n  = split_beat.ld_hour;
			day_n   = split_beat.ld_day;
			month_n = split_beat.ld_month;
			year_n  = split_beat.ld_year;
			cycle_n = split_beat.ld_cycle;
			wrap_n  = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sec_q       <= 6'd0;
			min_q       <= 6'd0;
			hour_q      <= 5'd0;
			day_q       <= 5'd1;
			month_q     <= MON_JAN;
			year_q      <= 14'd0;
			cycle_q     <= 9'd0;
			res_valid_q <= 1'b0;
		end else begin
			if (split_take) res_valid_q <= split_valid;
			if (step) begin
				sec_q   <= sec_n;
				min_q   <= min_n;
				hour_q  <= hour_n;
				day_q   <= day_n;
				month_q <= month_n;
				year_q  <= year_n;
				cycle_q <= cycle_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_q.cur_year     <= year_n;
			res_q.cur_month    <= month_n;
			res_q.cur_day      <= day_n;
			res_q.cur_hour     <= hour_n;
			res_q.cur_minute   <= min_n;
			res_q.cur_second   <= sec_n;
			res_q.year_wrapped <= wrap_n;
		end
	end

	a_time_range: assert property (@(posedge clk) disable iff (!arst_n)
		sec_q < 6'd60 && min_q < 6'd60 && hour_q < 5'd24 && cycle_q < 9'd400)
		else $error("time counter or year cycle out of range");

	a_day_fits: assert property (@(posedge clk) disable iff (!arst_n)
		day_q >= 5'd1 && day_q <= len_cur)
		else $error("day counter past end of month");

	a_wrap_new_year: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_q.year_wrapped |->
		res_q.cur_year == 14'd0 && res_q.cur_month == MON_JAN && cycle_q == 9'd0)
		else $error("year wrap without rollover to January of year zero");

	a_res_tracks_state: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> res_q.cur_second == sec_q && res_q.cur_minute == min_q &&
		res_q.cur_hour == hour_q && res_q.cur_day == day_q &&
		res_q.cur_month == month_q && res_q.cur_year == year_q)
		else $error("held result differs from calendar state");

endmodule

/* rtl/calendar_clock_advance_top.sv */
// ============================================================================
// calendar_clock_advance_top: Gregorian calendar clock
// Load or advance a second-resolution calendar; one result beat per command.
// ============================================================================
// Each command beat either loads second, minute, hour, day, month and year
// (every field saturated to its legal range, the day to the length of the
// loaded month in the loaded year) or advances the clock by the low
// DELTA_WIDTH bits of delta_seconds. Every command returns one result beat
// with the date and time after it; year_wrapped marks an advance that rolled
// the year from 16383 to 0. A new command is taken on every clock while the
// result side keeps up, so the sustained rate is one beat per cycle. Result
// valid rises once the edge that accepts the command has loaded the input
// register and the beat has passed the stages that split the delta into
// second, minute, hour and day digits by constant-reciprocal multiplies and
// the calendar update that writes the counters and the result register in
// the same cycle. That update is the only loop: each field adds its digit
// plus one carry, and at most one month carry ripples into the year. The
// result register and the pipeline stages absorb a stalled result; the
// command side stalls only once all are full. The calendar counters reset
// to 00:00:00 on January 1 of year 0.
// ============================================================================
module calendar_clock_advance_top import cca_pkg::*; #(
	parameter int unsigned DELTA_WIDTH = DELTA_WIDTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cmd_valid,
	output logic      cmd_stall,
	input  cmd_beat_t cmd,
	output logic      res_valid,
	input  logic      res_stall,
	output res_beat_t res
);

	// split pipeline to calendar update
	logic        split_valid;
	logic        split_take;
	split_beat_t split_beat;

	// split the delta and clamp the load fields ahead of the state update
	cca_split #(
		.DELTA_WIDTH (DELTA_WIDTH)
	) u_split (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (cmd_valid),
		.cmd_stall   (cmd_stall),
		.cmd         (cmd),
		.split_valid (split_valid),
		.split_take  (split_take),
		.split_beat  (split_beat)
	);

	// hold the calendar, advance or load it, register the result beat
	cca_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.split_valid (split_valid),
		.split_take  (split_take),
		.split_beat  (split_beat),
		.res_valid   (res_valid),
		.res_stall   (res_stall),
		.res         (res)
	);

endmodule
